FILE: rtl/utf8_greedy_line_wrapper_assert.svh
// Assertion macros shared by the line wrapper RTL.
// Needs nothing else; included by the modules that carry checks.
`ifndef UTF8_GREEDY_LINE_WRAPPER_ASSERT_SVH
`define UTF8_GREEDY_LINE_WRAPPER_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define UGLW_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define UGLW_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/uglw_pkg.sv
// Shared types, constants and helpers for the UTF-8 line wrapper.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package uglw_pkg;

  localparam int MARKER_LEN  = 7;
  localparam int BUF_DEPTH   = 7;
  localparam int CNT_W       = $clog2(BUF_DEPTH + 1);
  localparam int BYTE_W      = 8;
  localparam int CPL_W       = 10;
  localparam int WIDTH_W     = 14;
  localparam int LINE_W      = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [CPL_W-1:0]  CPL_RESET = 10'd20;
  localparam logic [LINE_W-1:0] LINE_MAX  = '1;

  localparam logic [2:0] NARROW_COST = 3'd2;
  localparam logic [2:0] WIDE_COST   = 3'd5;

  localparam logic [BYTE_W-1:0] CHR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHR_LF = 8'h0A;

  // UTF-8 lead byte masks and patterns
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_PAT   = 8'h80;

  // "<enter>"
  localparam logic [BYTE_W-1:0] MARKER [MARKER_LEN] =
    '{8'h3C, 8'h65, 8'h6E, 8'h74, 8'h65, 8'h72, 8'h3E};

  typedef enum logic {
    KIND_CHAR = 1'b0,
    KIND_EOL  = 1'b1
  } kind_t;

  // Byte plus the flags the front works out for it
  typedef struct packed {
    logic [BYTE_W-1:0]     data;
    logic [MARKER_LEN-1:0] mk;        // mk[j]: byte equals marker character j
    logic                  cont;      // continuation byte 10xxxxxx
    logic                  cr;
    logic                  lf;
    logic [2:0]            lead_len;  // 1..4
  } cls_t;

  typedef struct packed {
    logic has_byte;
    logic end_of_text;
    cls_t cls;
  } item_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic [LINE_W-1:0] line;
  } result_t;

  // Width limit is five units per full-width character; zero reads as one
  function automatic logic [WIDTH_W-1:0] width_limit(input logic [CPL_W-1:0] cpl);
    logic [CPL_W-1:0] c;
    c = (cpl == '0) ? CPL_W'(1) : cpl;
    return WIDTH_W'({c, 2'b00}) + WIDTH_W'(c);
  endfunction

endpackage

FILE: rtl/uglw_front.sv
// Front end: takes text words and tags each byte with its class flags.
// Depends on uglw_pkg; feeds uglw_fifo.
`timescale 1ns / 1ps

module uglw_front (
  input  logic                      text_valid,
  output logic                      text_stall,
  input  logic                      has_byte,
  input  logic [uglw_pkg::BYTE_W-1:0] text_byte,
  input  logic                      end_of_text,
  input  logic                      q_full,
  output logic                      q_push,
  output uglw_pkg::item_t           q_item
);
  import uglw_pkg::*;

  cls_t cls;

  always_comb begin
    cls.data = text_byte;
    for (int j = 0; j < MARKER_LEN; j++) begin
      cls.mk[j] = (text_byte == MARKER[j]);
    end
    cls.cont = ((text_byte & CONT_MASK) == CONT_PAT);
    cls.cr   = (text_byte == CHR_CR);
    cls.lf   = (text_byte == CHR_LF);
    if ((text_byte & LEAD2_MASK) == LEAD2_PAT) begin
      cls.lead_len = 3'd2;
    end else if ((text_byte & LEAD3_MASK) == LEAD3_PAT) begin
      cls.lead_len = 3'd3;
    end else if ((text_byte & LEAD4_MASK) == LEAD4_PAT) begin
      cls.lead_len = 3'd4;
    end else begin
      cls.lead_len = 3'd1;
    end
  end

  assign text_stall         = q_full;
  assign q_push             = text_valid && !q_full;
  assign q_item.has_byte    = has_byte;
  assign q_item.end_of_text = end_of_text;
  assign q_item.cls         = cls;

endmodule

FILE: rtl/uglw_fifo.sv
// Short word queue between front and back end.
// Depends on uglw_pkg and the assertion header.
`timescale 1ns / 1ps
`include "utf8_greedy_line_wrapper_assert.svh"

module uglw_fifo #(
  parameter int DEPTH = uglw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  uglw_pkg::item_t wr_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output uglw_pkg::item_t rd_data
);
  import uglw_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  item_t              mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_QW-1:0]  count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_QW'(1);
        2'b01:   count <= count - CNT_QW'(1);
        default: count <= count;
      endcase
    end
  end

  assign full      = (count == CNT_QW'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  `UGLW_ASSERT_ALWAYS(a_no_overflow, clk, rst, !(push && full), "queue written while full")
  `UGLW_ASSERT_ALWAYS(a_no_underflow, clk, rst, !(pop && !not_empty), "queue read while empty")

endmodule

FILE: rtl/uglw_back.sv
// Back end: lookahead buffer, wrap sequencer and result output stage.
// Depends on uglw_pkg and the assertion header; fed by uglw_fifo.
`timescale 1ns / 1ps
`include "utf8_greedy_line_wrapper_assert.svh"

module uglw_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [uglw_pkg::CPL_W-1:0]  cfg_wr_data,
  input  logic                        q_valid,
  input  uglw_pkg::item_t             q_item,
  output logic                        q_pop,
  output logic                        wrap_valid,
  input  logic                        wrap_stall,
  output logic                        kind,
  output logic [uglw_pkg::BYTE_W-1:0] out_byte,
  output logic [uglw_pkg::LINE_W-1:0] line_index,
  output logic                        last_of_run
);
  import uglw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_BYTES,
    ST_CLOSE,
    ST_FLUSH
  } state_t;

  typedef enum logic [2:0] {
    DEC_DONE,   // buffer empty or head undecided
    DEC_SKIP,   // LF straight after CR
    DEC_MARK,   // full marker
    DEC_BREAK,  // CR or LF
    DEC_WRAP,   // close line before the head character
    DEC_PLACE   // place head character
  } dec_t;

  state_t             state;
  cls_t               la_buf [BUF_DEPTH];
  logic [CNT_W-1:0]   la_cnt;
  logic               pend_cr;
  logic [WIDTH_W-1:0] width_used;
  logic [LINE_W-1:0]  cur_line;
  logic               text_started;
  logic               item_end;
  logic               final_pass;
  logic [1:0]         rem;
  logic [CPL_W-1:0]   cpl;
  logic [WIDTH_W-1:0] limit;

  logic               hold_vld;
  result_t            hold;
  logic               out_vld;
  result_t            out_res;
  logic               out_last;

  cls_t               head;
  logic               prefix_ok;
  logic               cwait;
  logic               stop;
  logic [2:0]         clen;
  logic [2:0]         cost;
  logic [WIDTH_W:0]   sum;
  dec_t               dec;
  logic               out_free;
  logic               slot_ok;
  logic               flush_done;
  logic               load_now;
  logic               emit_req;
  logic               emit_fire;
  result_t            emit_res;
  logic [LINE_W-1:0]  line_inc;

  assign head = la_buf[0];

  // Head decision over the lookahead buffer
  always_comb begin
    prefix_ok = 1'b1;
    for (int j = 0; j < MARKER_LEN; j++) begin
      if ((CNT_W'(j) < la_cnt) && !la_buf[j].mk[j]) begin
        prefix_ok = 1'b0;
      end
    end

    clen  = head.lead_len;
    cwait = 1'b0;
    stop  = 1'b0;
    for (int i = 1; i < 4; i++) begin
      if (!stop && (3'(i) < head.lead_len)) begin
        if (CNT_W'(i) >= la_cnt) begin
          if (final_pass) begin
            clen = 3'd1;
          end else begin
            cwait = 1'b1;
          end
          stop = 1'b1;
        end else if (!la_buf[i].cont) begin
          clen = 3'd1;
          stop = 1'b1;
        end
      end
    end

    cost = (clen == 3'd1) ? NARROW_COST : WIDE_COST;
    sum  = {1'b0, width_used} + (WIDTH_W + 1)'(cost);

    if (la_cnt == '0) begin
      dec = DEC_DONE;
    end else if (pend_cr && head.lf) begin
      dec = DEC_SKIP;
    end else if (prefix_ok && (la_cnt == CNT_W'(MARKER_LEN))) begin
      dec = DEC_MARK;
    end else if (prefix_ok && !final_pass) begin
      dec = DEC_DONE;
    end else if (head.cr || head.lf) begin
      dec = DEC_BREAK;
    end else if (cwait) begin
      dec = DEC_DONE;
    end else if ((width_used != '0) && (sum > {1'b0, limit})) begin
      dec = DEC_WRAP;
    end else begin
      dec = DEC_PLACE;
    end
  end

  // Result request for this cycle
  always_comb begin
    emit_req      = 1'b0;
    emit_res.kind = KIND_EOL;
    emit_res.data = '0;
    emit_res.line = cur_line;
    unique case (state)
      ST_EVAL: begin
        case (dec)
          DEC_MARK, DEC_BREAK, DEC_WRAP: emit_req = 1'b1;
          DEC_PLACE: begin
            emit_req      = 1'b1;
            emit_res.kind = KIND_CHAR;
            emit_res.data = head.data;
          end
          default: emit_req = 1'b0;
        endcase
      end
      ST_BYTES: begin
        emit_req      = 1'b1;
        emit_res.kind = KIND_CHAR;
        emit_res.data = head.data;
      end
      ST_CLOSE: emit_req = 1'b1;
      default:  emit_req = 1'b0;
    endcase
  end

  assign out_free   = !out_vld || !wrap_stall;
  assign slot_ok    = !hold_vld || out_free;
  assign emit_fire  = emit_req && slot_ok;
  assign flush_done = !hold_vld || out_free;
  assign load_now   = q_valid &&
                      ((state == ST_IDLE) || ((state == ST_FLUSH) && flush_done && !item_end));
  assign q_pop      = load_now;
  assign line_inc   = (cur_line == LINE_MAX) ? cur_line : cur_line + LINE_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      la_cnt       <= '0;
      pend_cr      <= 1'b0;
      width_used   <= '0;
      cur_line     <= '0;
      text_started <= 1'b0;
      item_end     <= 1'b0;
      final_pass   <= 1'b0;
      rem          <= '0;
      cpl          <= CPL_RESET;
      limit        <= width_limit(CPL_RESET);
      hold_vld     <= 1'b0;
      out_vld      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cpl <= cfg_wr_data;
      end
      limit <= width_limit(cpl);

      // Output stage: the newest result waits in hold until we know
      // whether another one follows for the same word
      if (emit_fire) begin
        if (hold_vld) begin
          out_res  <= hold;
          out_last <= 1'b0;
          out_vld  <= 1'b1;
        end else if (out_vld && !wrap_stall) begin
          out_vld <= 1'b0;
        end
        hold     <= emit_res;
        hold_vld <= 1'b1;
      end else if ((state == ST_FLUSH) && hold_vld && out_free) begin
        out_res  <= hold;
        out_last <= 1'b1;
        out_vld  <= 1'b1;
        hold_vld <= 1'b0;
      end else if (out_vld && !wrap_stall) begin
        out_vld <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
        end
        ST_EVAL: begin
          case (dec)
            DEC_DONE: begin
              if (la_cnt != '0) begin
                pend_cr <= 1'b0;
              end
              if (final_pass) begin
                state <= ST_CLOSE;
              end else if (item_end) begin
                final_pass <= 1'b1;
              end else begin
                state <= ST_FLUSH;
              end
            end
            DEC_SKIP: begin
              pend_cr <= 1'b0;
              for (int j = 0; j < BUF_DEPTH - 1; j++) la_buf[j] <= la_buf[j+1];
              la_buf[BUF_DEPTH-1] <= '0;
              la_cnt <= la_cnt - CNT_W'(1);
            end
            DEC_MARK: begin
              if (slot_ok) begin
                pend_cr    <= 1'b0;
                cur_line   <= line_inc;
                width_used <= '0;
                la_cnt     <= '0;
              end
            end
            DEC_BREAK: begin
              if (slot_ok) begin
                pend_cr    <= head.cr;
                cur_line   <= line_inc;
                width_used <= '0;
                for (int j = 0; j < BUF_DEPTH - 1; j++) la_buf[j] <= la_buf[j+1];
                la_buf[BUF_DEPTH-1] <= '0;
                la_cnt <= la_cnt - CNT_W'(1);
              end
            end
            DEC_WRAP: begin
              // re-evaluated next cycle with an empty line
              if (slot_ok) begin
                pend_cr    <= 1'b0;
                cur_line   <= line_inc;
                width_used <= '0;
              end
            end
            DEC_PLACE: begin
              if (slot_ok) begin
                pend_cr    <= 1'b0;
                width_used <= width_used + WIDTH_W'(cost);
                for (int j = 0; j < BUF_DEPTH - 1; j++) la_buf[j] <= la_buf[j+1];
                la_buf[BUF_DEPTH-1] <= '0;
                la_cnt <= la_cnt - CNT_W'(1);
                rem    <= 2'(clen - 3'd1);
                if (clen != 3'd1) begin
                  state <= ST_BYTES;
                end
              end
            end
            default: state <= ST_EVAL;
          endcase
        end
        ST_BYTES: begin
          if (slot_ok) begin
            for (int j = 0; j < BUF_DEPTH - 1; j++) la_buf[j] <= la_buf[j+1];
            la_buf[BUF_DEPTH-1] <= '0;
            la_cnt <= la_cnt - CNT_W'(1);
            rem    <= rem - 2'd1;
            if (rem == 2'd1) begin
              state <= ST_EVAL;
            end
          end
        end
        ST_CLOSE: begin
          if (slot_ok) begin
            cur_line   <= line_inc;
            width_used <= '0;
            state      <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (flush_done) begin
            if (item_end) begin
              la_cnt       <= '0;
              pend_cr      <= 1'b0;
              width_used   <= '0;
              cur_line     <= '0;
              text_started <= 1'b0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      // Take the next queued word; overrides the state chosen above
      if (load_now) begin
        item_end   <= q_item.end_of_text;
        final_pass <= 1'b0;
        if (q_item.has_byte) begin
          text_started <= 1'b1;
          if (la_cnt < CNT_W'(BUF_DEPTH)) begin
            la_buf[la_cnt] <= q_item.cls;
            la_cnt         <= la_cnt + CNT_W'(1);
          end
          state <= ST_EVAL;
        end else if (q_item.end_of_text && text_started) begin
          final_pass <= 1'b1;
          state      <= ST_EVAL;
        end else begin
          state <= ST_FLUSH;
        end
      end
    end
  end

  assign wrap_valid  = out_vld;
  assign kind        = out_res.kind;
  assign out_byte    = out_res.data;
  assign line_index  = out_res.line;
  assign last_of_run = out_last;

  `UGLW_ASSERT_IMPLIES(a_idle_hold_empty, clk, rst, state == ST_IDLE, !hold_vld, "result left in hold while idle")
  `UGLW_ASSERT_IMPLIES(a_bytes_cont, clk, rst, state == ST_BYTES, (la_cnt != '0) && la_buf[0].cont, "tail byte of character missing")
  `UGLW_ASSERT_IMPLIES(a_close_final, clk, rst, state == ST_CLOSE, final_pass && text_started, "closing line outside end of text")

endmodule

FILE: rtl/utf8_greedy_line_wrapper.sv
// UTF-8 greedy line wrapper, top level. A word is one text byte and/or end mark.
// Path: a taken word enters the lookahead buffer, the sequencer decides on it, and each result
// passes the hold register to the output register. The back-end sequencer handles one decision per
// cycle while its result slot is free; a new word is taken only once the last one is flushed.
// Reset: synchronous on rst; queue and buffer emptied, chars_per_line back to 20.
`timescale 1ns / 1ps

module utf8_greedy_line_wrapper #(
  parameter int QUEUE_DEPTH = uglw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // register write: chars_per_line
  input  logic                        cfg_wr_en,
  input  logic [uglw_pkg::CPL_W-1:0]  cfg_wr_data,
  // text words in
  input  logic                        text_valid,
  output logic                        text_stall,
  input  logic                        has_byte,
  input  logic [uglw_pkg::BYTE_W-1:0] text_byte,
  input  logic                        end_of_text,
  // wrapped results out
  output logic                        wrap_valid,
  input  logic                        wrap_stall,
  output logic                        kind,
  output logic [uglw_pkg::BYTE_W-1:0] out_byte,
  output logic [uglw_pkg::LINE_W-1:0] line_index,
  output logic                        last_of_run
);
  import uglw_pkg::*;

  // Front tags each byte (marker position hits, CR/LF, UTF-8 lead length,
  // continuation) so the back end only compares flags.
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;
  item_t q_wr;
  item_t q_rd;

  uglw_front u_front (
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .has_byte    (has_byte),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_wr)
  );

  // Queue lets the input side keep taking words while the back end is
  // busy flushing a long burst of results.
  uglw_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_data   (q_wr),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rd_data   (q_rd)
  );

  // Back end holds the seven-byte lookahead, decides one character, marker
  // or line end per step, and wraps greedily against five units per
  // full-width character. The last result of each word waits in the hold register
  // so that last_of_run can be set on it.
  uglw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_item      (q_rd),
    .q_pop       (q_pop),
    .wrap_valid  (wrap_valid),
    .wrap_stall  (wrap_stall),
    .kind        (kind),
    .out_byte    (out_byte),
    .line_index  (line_index),
    .last_of_run (last_of_run)
  );

endmodule
